@@ hw/rtl/rfvs_pkg.sv @@
`default_nettype none

package rfvs_pkg;

	localparam int unsigned STACK_BYTES = 1024;
	localparam int unsigned WORD_BYTES  = 4;
	localparam int unsigned STORE_DEPTH = 256;
	localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);
	localparam int unsigned COUNT_W     = STORE_AW + 1;
	localparam int unsigned LIMIT_RAW   = STACK_BYTES / WORD_BYTES;
	localparam int unsigned STACK_LIMIT = (LIMIT_RAW > STORE_DEPTH) ? STORE_DEPTH : LIMIT_RAW;

	localparam int unsigned NUM_REGS = 32;
	localparam int unsigned REG_AW   = 5;
	localparam int unsigned DATA_W   = 32;
	localparam logic [REG_AW-1:0] SP_REG = REG_AW'(29);

	localparam int unsigned IN_TDATA_W  = 40;
	localparam int unsigned OUT_TDATA_W = 40;

	typedef enum logic [2:0] {
		MODE_READ  = 3'd0,
		MODE_WRITE = 3'd1,
		MODE_PUSH  = 3'd2,
		MODE_POP   = 3'd3,
		MODE_OVR   = 3'd4,
		MODE_RTOP  = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		STS_DONE  = 2'd0,
		STS_EMPTY = 2'd1,
		STS_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

`default_nettype wire

@@ hw/rtl/register_file_with_value_stack_unit.sv @@
// Register file of thirty-two 32-bit registers plus a value stack of up to 256
// words. Each input transaction carries a mode (read, write, push, pop,
// overwrite top, read top), a register number and a write value, and yields
// one output transaction with the addressed register after the operation and
// a status (done, stack empty refused, stack full refused). Register 29 is the
// stack pointer: it resets to the stack size in bytes, push lowers it by one
// word and pop raises it. After reset the stack holds one zero entry. Every
// transaction is accepted in idle, where the register and stack memories are
// read (synchronous read), and is then modified and written back in the
// execute state; a new transaction is taken only after the previous one has
// finished and its result has been or is being taken at the output.
`default_nettype none

module register_file_with_value_stack_unit #(
	parameter int unsigned STACK_BYTES = rfvs_pkg::STACK_BYTES,
	parameter int unsigned WORD_BYTES  = rfvs_pkg::WORD_BYTES
) (
	input  wire  logic                                   clk,
	input  wire  logic                                   arst_n,
	input  wire  logic                                   s_tvalid,
	output logic                                         s_tready,
	// mode[2:0], reg_index[7:3], write_value[39:8]
	input  wire  logic [rfvs_pkg::IN_TDATA_W-1:0]        s_tdata,
	output logic                                         m_tvalid,
	input  wire  logic                                   m_tready,
	// read_value[31:0], status[33:32], zero[39:34]
	output logic [rfvs_pkg::OUT_TDATA_W-1:0]             m_tdata
);

	localparam int unsigned DW  = rfvs_pkg::DATA_W;
	localparam int unsigned AW  = rfvs_pkg::STORE_AW;
	localparam int unsigned CW  = rfvs_pkg::COUNT_W;
	localparam int unsigned RAW = rfvs_pkg::REG_AW;
	localparam int unsigned LIMIT_RAW = STACK_BYTES / WORD_BYTES;
	localparam int unsigned LIMIT_N   = (LIMIT_RAW > rfvs_pkg::STORE_DEPTH) ?
	                                    rfvs_pkg::STORE_DEPTH : LIMIT_RAW;
	localparam logic [DW-1:0] WORD_STEP = DW'(WORD_BYTES);
	localparam logic [DW-1:0] SP_RESET  = DW'(STACK_BYTES);
	localparam logic [CW-1:0] LIMIT_C   = CW'(LIMIT_N);

	logic [DW-1:0] reg_mem [rfvs_pkg::NUM_REGS];
	logic [DW-1:0] stk_mem [rfvs_pkg::STORE_DEPTH];

	rfvs_pkg::state_t  state_q, state_d;
	logic [rfvs_pkg::NUM_REGS-1:0] reg_valid_q;
	logic              stk0_valid_q;
	logic [CW-1:0]     count_q;
	logic [DW-1:0]     sp_q;
	logic              m_tvalid_q;
	logic [DW-1:0]     out_value_q;
	rfvs_pkg::status_t out_status_q;

	rfvs_pkg::mode_t   mode_s1;
	logic [RAW-1:0]    idx_s1;
	logic [DW-1:0]     wval_s1;
	logic [AW-1:0]     top_s1;
	logic [DW-1:0]     reg_rd_s1;
	logic [DW-1:0]     stk_rd_s1;

	logic              accept;
	logic [AW-1:0]     top_now;
	logic [DW-1:0]     rval;
	logic [DW-1:0]     top_val;
	logic              empty;
	logic              full;
	logic              reg_we;
	logic [DW-1:0]     reg_wd;
	logic              stk_we;
	logic [AW-1:0]     stk_wa;
	logic [DW-1:0]     stk_wd;
	logic [CW-1:0]     count_d;
	logic [DW-1:0]     sp_d;
	logic [DW-1:0]     res_value;
	rfvs_pkg::status_t res_status;

	assign accept  = s_tvalid && s_tready;
	assign top_now = AW'(count_q - CW'(1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rfvs_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = rfvs_pkg::ST_EXEC;
				end
			end
			rfvs_pkg::ST_EXEC: begin
				state_d = rfvs_pkg::ST_IDLE;
			end
			default: begin
				state_d = rfvs_pkg::ST_IDLE;
			end
		endcase
	end

	// handshake outputs
	always_comb begin
		s_tready = 1'b0;
		unique case (state_q)
			rfvs_pkg::ST_IDLE: s_tready = !m_tvalid_q || m_tready;
			rfvs_pkg::ST_EXEC: s_tready = 1'b0;
			default:           s_tready = 1'b0;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(rfvs_pkg::OUT_TDATA_W - DW - 2){1'b0}}, out_status_q, out_value_q};

	// operand fetch
	assign rval    = (idx_s1 == rfvs_pkg::SP_REG) ? sp_q :
	                 (reg_valid_q[idx_s1] ? reg_rd_s1 : '0);
	assign top_val = ((top_s1 == '0) && !stk0_valid_q) ? '0 : stk_rd_s1;
	assign empty   = (count_q == '0);
	assign full    = (count_q >= LIMIT_C);

	// modify
	always_comb begin
		reg_we     = 1'b0;
		reg_wd     = wval_s1;
		stk_we     = 1'b0;
		stk_wa     = top_s1;
		stk_wd     = rval;
		count_d    = count_q;
		sp_d       = sp_q;
		res_status = rfvs_pkg::STS_DONE;
		unique case (mode_s1)
			rfvs_pkg::MODE_WRITE: begin
				reg_we = 1'b1;
				reg_wd = wval_s1;
			end
			rfvs_pkg::MODE_PUSH: begin
				if (empty) begin
					res_status = rfvs_pkg::STS_EMPTY;
				end else if (full) begin
					res_status = rfvs_pkg::STS_FULL;
				end else begin
					stk_we  = 1'b1;
					stk_wa  = AW'(count_q);
					count_d = count_q + CW'(1);
				end
			end
			rfvs_pkg::MODE_POP: begin
				if (empty) begin
					res_status = rfvs_pkg::STS_EMPTY;
				end else begin
					reg_we  = 1'b1;
					reg_wd  = top_val;
					count_d = count_q - CW'(1);
				end
			end
			rfvs_pkg::MODE_OVR: begin
				if (empty) begin
					res_status = rfvs_pkg::STS_EMPTY;
				end else begin
					stk_we = 1'b1;
				end
			end
			rfvs_pkg::MODE_RTOP: begin
				if (empty) begin
					res_status = rfvs_pkg::STS_EMPTY;
				end else begin
					reg_we = 1'b1;
					reg_wd = top_val;
				end
			end
			default: begin
			end
		endcase
		if (reg_we && (idx_s1 == rfvs_pkg::SP_REG)) begin
			sp_d = reg_wd;
		end
		// stack pointer follows the stack after the register write
		if ((mode_s1 == rfvs_pkg::MODE_PUSH) && stk_we) begin
			sp_d = sp_q - WORD_STEP;
		end else if ((mode_s1 == rfvs_pkg::MODE_POP) && reg_we) begin
			sp_d = sp_d + WORD_STEP;
		end
		if (idx_s1 == rfvs_pkg::SP_REG) begin
			res_value = sp_d;
		end else if (reg_we) begin
			res_value = reg_wd;
		end else begin
			res_value = rval;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rfvs_pkg::ST_IDLE;
			reg_valid_q  <= '0;
			stk0_valid_q <= 1'b0;
			count_q      <= CW'(1);
			sp_q         <= SP_RESET;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rfvs_pkg::ST_EXEC) begin
				count_q <= count_d;
				sp_q    <= sp_d;
				if (reg_we) begin
					reg_valid_q[idx_s1] <= 1'b1;
				end
				if (stk_we && (stk_wa == '0)) begin
					stk0_valid_q <= 1'b1;
				end
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// transaction capture and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= rfvs_pkg::mode_t'(s_tdata[2:0]);
			idx_s1  <= s_tdata[7:3];
			wval_s1 <= s_tdata[39:8];
			top_s1  <= top_now;
		end
		if (state_q == rfvs_pkg::ST_EXEC) begin
			out_value_q  <= res_value;
			out_status_q <= res_status;
		end
	end

	// register memory
	always_ff @(posedge clk) begin
		if (accept) begin
			reg_rd_s1 <= reg_mem[s_tdata[7:3]];
		end
		if ((state_q == rfvs_pkg::ST_EXEC) && reg_we) begin
			reg_mem[idx_s1] <= reg_wd;
		end
	end

	// stack memory
	always_ff @(posedge clk) begin
		if (accept) begin
			stk_rd_s1 <= stk_mem[top_now];
		end
		if ((state_q == rfvs_pkg::ST_EXEC) && stk_we) begin
			stk_mem[stk_wa] <= stk_wd;
		end
	end

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LIMIT_C)
		else $error("stack count above limit");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (state_q == rfvs_pkg::ST_IDLE))
		else $error("ready while busy");

	a_out_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == rfvs_pkg::ST_EXEC))
		else $error("result without execute cycle");

	a_refused_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == rfvs_pkg::ST_EXEC) && (res_status != rfvs_pkg::STS_DONE))
		|=> ($stable(count_q) && $stable(sp_q)))
		else $error("refused operation changed stack");

	a_sp_only_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rfvs_pkg::ST_IDLE) |=> $stable(sp_q))
		else $error("stack pointer changed outside execute");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`default_nettype none

module tb_top;

	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_CYCLES = 10;

	typedef struct packed {
		logic [rfvs_pkg::DATA_W-1:0] read_value;
		rfvs_pkg::status_t           status;
	} reg_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [rfvs_pkg::IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b1;
	logic [rfvs_pkg::OUT_TDATA_W-1:0] m_tdata;

	// golden copy of the register file and the stack
	logic [rfvs_pkg::DATA_W-1:0] gpr_model [rfvs_pkg::NUM_REGS];
	logic [rfvs_pkg::DATA_W-1:0] stack_model [rfvs_pkg::STORE_DEPTH];
	logic [rfvs_pkg::COUNT_W-1:0] stack_depth;

	reg_result_t pending_reg_reads [$];
	reg_result_t want;
	bit idle_en = 1'b0;
	int unsigned stall_left = 0;
	int unsigned cycle_count = 0;
	int unsigned failures = 0;
	int unsigned ops_sent = 0;
	int unsigned empty_refusals = 0;
	int unsigned full_refusals = 0;
	int unsigned results_seen = 0;

	register_file_with_value_stack_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void regfile_reset();
		foreach (gpr_model[i]) gpr_model[i] = '0;
		foreach (stack_model[i]) stack_model[i] = '0;
		gpr_model[rfvs_pkg::SP_REG] = rfvs_pkg::DATA_W'(rfvs_pkg::STACK_BYTES);
		stack_depth = rfvs_pkg::COUNT_W'(1);
	endfunction

	function automatic reg_result_t regfile_apply(input logic [2:0] mode,
			input logic [rfvs_pkg::REG_AW-1:0] idx,
			input logic [rfvs_pkg::DATA_W-1:0] wval);
		reg_result_t res;
		logic [rfvs_pkg::STORE_AW-1:0] top;
		rfvs_pkg::status_t sts;
		top = rfvs_pkg::STORE_AW'(stack_depth - rfvs_pkg::COUNT_W'(1));
		sts = rfvs_pkg::STS_DONE;
		case (mode)
			rfvs_pkg::MODE_WRITE: gpr_model[idx] = wval;
			rfvs_pkg::MODE_PUSH: begin
				if (stack_depth == 0) begin
					sts = rfvs_pkg::STS_EMPTY;
				end else if (stack_depth >= rfvs_pkg::STACK_LIMIT) begin
					sts = rfvs_pkg::STS_FULL;
				end else begin
					stack_model[rfvs_pkg::STORE_AW'(stack_depth)] = gpr_model[idx];
					stack_depth = stack_depth + rfvs_pkg::COUNT_W'(1);
					gpr_model[rfvs_pkg::SP_REG] = gpr_model[rfvs_pkg::SP_REG] -
						rfvs_pkg::DATA_W'(rfvs_pkg::WORD_BYTES);
				end
			end
			rfvs_pkg::MODE_POP: begin
				if (stack_depth == 0) begin
					sts = rfvs_pkg::STS_EMPTY;
				end else begin
					stack_depth = stack_depth - rfvs_pkg::COUNT_W'(1);
					gpr_model[idx] = stack_model[top];
					gpr_model[rfvs_pkg::SP_REG] = gpr_model[rfvs_pkg::SP_REG] +
						rfvs_pkg::DATA_W'(rfvs_pkg::WORD_BYTES);
				end
			end
			rfvs_pkg::MODE_OVR: begin
				if (stack_depth == 0) sts = rfvs_pkg::STS_EMPTY;
				else stack_model[top] = gpr_model[idx];
			end
			rfvs_pkg::MODE_RTOP: begin
				if (stack_depth == 0) sts = rfvs_pkg::STS_EMPTY;
				else gpr_model[idx] = stack_model[top];
			end
			default: ;
		endcase
		if (sts == rfvs_pkg::STS_EMPTY) empty_refusals++;
		if (sts == rfvs_pkg::STS_FULL) full_refusals++;
		res.read_value = gpr_model[idx];
		res.status = sts;
		return res;
	endfunction

	// entered and left at a falling edge
	task automatic send_op(input logic [2:0] mode, input logic [rfvs_pkg::REG_AW-1:0] idx,
			input logic [rfvs_pkg::DATA_W-1:0] wval);
		reg_result_t exp_res;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {wval, idx, mode};
		do @(posedge clk); while (!s_tready);
		exp_res = regfile_apply(mode, idx, wval);
		pending_reg_reads = {pending_reg_reads, exp_res};
		ops_sent++;
		@(negedge clk);
	endtask

	function automatic logic [rfvs_pkg::DATA_W-1:0] pick_value();
		if ($urandom_range(0, 9) != 0) return $urandom;
		case ($urandom_range(0, 3))
			0: return 32'h0000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h8000_0000;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	task automatic test_basic_ops();
		idle_en = 1'b1;
		send_op(rfvs_pkg::MODE_READ, 5'd0, 32'hffff_ffff);
		send_op(rfvs_pkg::MODE_READ, rfvs_pkg::SP_REG, 32'h0);
		send_op(rfvs_pkg::MODE_WRITE, 5'd0, 32'h7fff_ffff);
		send_op(rfvs_pkg::MODE_READ, 5'd0, 32'h0);
		send_op(rfvs_pkg::MODE_WRITE, 5'd31, 32'h8000_0000);
		send_op(rfvs_pkg::MODE_WRITE, 5'd1, 32'hffff_ffff);
		send_op(rfvs_pkg::MODE_PUSH, 5'd31, 32'h0);
		// saved value is the pointer before it moves
		send_op(rfvs_pkg::MODE_PUSH, rfvs_pkg::SP_REG, 32'h0);
		send_op(rfvs_pkg::MODE_RTOP, 5'd3, 32'h0);
		send_op(rfvs_pkg::MODE_OVR, 5'd1, 32'h0);
		send_op(rfvs_pkg::MODE_RTOP, 5'd4, 32'h0);
		// popped value lands first, then the pointer steps up
		send_op(rfvs_pkg::MODE_POP, rfvs_pkg::SP_REG, 32'h0);
		send_op(rfvs_pkg::MODE_POP, 5'd5, 32'h0);
		send_op(MODE_SPARE6, 5'd1, 32'h1234_5678);
		send_op(MODE_SPARE7, 5'd31, 32'hdead_beef);
		// pointer wraps below zero and back
		send_op(rfvs_pkg::MODE_WRITE, rfvs_pkg::SP_REG, 32'h0000_0002);
		send_op(rfvs_pkg::MODE_PUSH, 5'd0, 32'h0);
		send_op(rfvs_pkg::MODE_READ, rfvs_pkg::SP_REG, 32'h0);
		send_op(rfvs_pkg::MODE_POP, 5'd2, 32'h0);
		send_op(rfvs_pkg::MODE_READ, rfvs_pkg::SP_REG, 32'h0);
		send_op(rfvs_pkg::MODE_WRITE, rfvs_pkg::SP_REG,
			rfvs_pkg::DATA_W'(rfvs_pkg::STACK_BYTES));
	endtask

	task automatic test_fill_to_full();
		idle_en = 1'b1;
		while (stack_depth < rfvs_pkg::STACK_LIMIT) begin
			if ($urandom_range(0, 3) == 0)
				send_op(rfvs_pkg::MODE_WRITE, rfvs_pkg::REG_AW'($urandom_range(0, 31)),
					pick_value());
			send_op(rfvs_pkg::MODE_PUSH, rfvs_pkg::REG_AW'($urandom_range(0, 31)), $urandom);
		end
		send_op(rfvs_pkg::MODE_PUSH, 5'd7, $urandom);
		send_op(rfvs_pkg::MODE_PUSH, rfvs_pkg::SP_REG, $urandom);
		send_op(rfvs_pkg::MODE_OVR, 5'd7, $urandom);
		send_op(rfvs_pkg::MODE_RTOP, 5'd8, $urandom);
		repeat (20)
			send_op(rfvs_pkg::MODE_POP, rfvs_pkg::REG_AW'($urandom_range(0, 31)), $urandom);
	endtask

	task automatic test_random_ops(input int unsigned n_ops);
		int unsigned seg_left;
		int unsigned r;
		bit grow;
		logic [2:0] mode;
		seg_left = 0;
		grow = 1'b0;
		for (int unsigned i = 0; i < n_ops; i++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(100, 300);
				grow = !grow;
				idle_en = ($urandom_range(0, 3) != 0);
			end
			seg_left--;
			if (stack_depth <= 2) grow = 1'b1;
			else if (stack_depth >= rfvs_pkg::STACK_LIMIT && $urandom_range(0, 15) == 0)
				grow = 1'b0;
			r = $urandom_range(0, 99);
			if (r < 10) mode = rfvs_pkg::MODE_READ;
			else if (r < 25) mode = rfvs_pkg::MODE_WRITE;
			else if (r < 33) mode = rfvs_pkg::MODE_OVR;
			else if (r < 41) mode = rfvs_pkg::MODE_RTOP;
			else if (r < 43) mode = ($urandom_range(0, 1) == 0) ? MODE_SPARE6 : MODE_SPARE7;
			else if ($urandom_range(0, 99) < (grow ? 85 : 15)) mode = rfvs_pkg::MODE_PUSH;
			else mode = rfvs_pkg::MODE_POP;
			// keep the stack alive until the closing test
			if (mode == rfvs_pkg::MODE_POP && stack_depth <= 1) mode = rfvs_pkg::MODE_RTOP;
			send_op(mode, rfvs_pkg::REG_AW'($urandom_range(0, 31)), pick_value());
		end
	endtask

	task automatic test_empty_stack();
		logic [2:0] mode;
		idle_en = 1'b0;
		while (stack_depth > 0)
			send_op(rfvs_pkg::MODE_POP, rfvs_pkg::REG_AW'($urandom_range(0, 31)), $urandom);
		send_op(rfvs_pkg::MODE_PUSH, 5'd0, $urandom);
		send_op(rfvs_pkg::MODE_POP, rfvs_pkg::SP_REG, $urandom);
		send_op(rfvs_pkg::MODE_OVR, 5'd9, $urandom);
		send_op(rfvs_pkg::MODE_RTOP, 5'd10, $urandom);
		send_op(rfvs_pkg::MODE_READ, rfvs_pkg::SP_REG, $urandom);
		repeat (60) begin
			mode = 3'($urandom_range(0, 7));
			send_op(mode, rfvs_pkg::REG_AW'($urandom_range(0, 31)), pick_value());
		end
	endtask

	always @(negedge clk) begin
		if (!arst_n || !idle_en) begin
			m_tready <= 1'b1;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 4) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 2);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_reg_reads.size() == 0) begin
				$error("unexpected result transaction: read_value %h status %0d",
					m_tdata[31:0], m_tdata[33:32]);
				failures++;
			end else begin
				want = pending_reg_reads.pop_front();
				if (m_tdata[31:0] !== want.read_value) begin
					$error("read_value mismatch: expected %h, actual %h",
						want.read_value, m_tdata[31:0]);
					failures++;
				end
				if (m_tdata[33:32] !== want.status) begin
					$error("status mismatch: expected %0d, actual %0d",
						want.status, m_tdata[33:32]);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_reg_reads.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		regfile_reset();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_basic_ops();
		test_fill_to_full();
		test_random_ops(1050);
		test_empty_stack();
		s_tvalid <= 1'b0;
		while (pending_reg_reads.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d operations checked over %0d results, stack driven to full and to empty",
			ops_sent, results_seen);
		$display("%0d pushes refused on a full stack, %0d operations refused on an empty one",
			full_refusals, empty_refusals);
		if (failures == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
hw/rtl/rfvs_pkg.sv
hw/rtl/register_file_with_value_stack_unit.sv
bench/tb_top.sv
